[sv/rctb_pkg.sv]
// Shared types and constants for the repeat count timer bank.
package rctb_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int MS_W      = 32;
  localparam int RATE_W    = 14;
  localparam int TICK_W    = 32;
  localparam int RUNS_W    = 16;
  localparam int TIMER_O_W = 3;

  // Run counter codes
  localparam logic [RUNS_W-1:0] RUNS_FOREVER = 16'hFFFF;
  localparam logic [RUNS_W-1:0] RUNS_STOPPED = 16'h0000;

  // Tick rate after reset
  localparam logic [RATE_W-1:0] TICK_RATE_RST = 14'd1000;

  // Millisecond conversion: divide by 1000 as a shift by 3 and a division by 125
  localparam int               PROD_W      = MS_W + RATE_W;
  localparam int               MS_SHIFT    = 3;
  localparam int               DIV_W       = 44;
  localparam int               DIV_BITS    = 4;
  localparam int               DIV_STEPS   = DIV_W / DIV_BITS;
  localparam int               REM_W       = 7;
  localparam int               DIV_CNT_W   = 4;
  localparam logic [REM_W-1:0] DIVISOR     = 7'd125;

  // Opcodes
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_SCAN  = 2'd3
  } rctb_op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_FLUSH
  } rctb_state_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic              tick;
    logic              stop;
    logic              load;
    logic              shift;
    logic              adv;
    logic [TICK_W-1:0] ticks;
    logic [RUNS_W-1:0] runs;
  } rctb_cmd_t;

  // Status returned by each cell
  typedef struct packed {
    logic tok;
    logic hit;
  } rctb_cell_st_t;

endpackage

[sv/rctb_ms2tick.sv]
// Millisecond to tick converter: one multiply, then a radix-16 long division by 125.
module rctb_ms2tick (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rctb_pkg::MS_W-1:0]           ms,
  input  logic [rctb_pkg::RATE_W-1:0]         rate,
  output logic                                done,
  output logic [rctb_pkg::TICK_W-1:0]         ticks
);

  logic [rctb_pkg::PROD_W-1:0]    prod;
  logic [rctb_pkg::DIV_W-1:0]     dq_r, dq_nxt;
  logic [rctb_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [rctb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  // Scale milliseconds by the tick rate
  assign prod = ms * rate;

  // Retire four quotient bits per cycle
  always_comb begin
    logic [rctb_pkg::DIV_W-1:0] dq;
    logic [rctb_pkg::REM_W-1:0] rem;
    logic [rctb_pkg::REM_W:0]   t;
    dq  = dq_r;
    rem = rem_r;
    for (int k = 0; k < rctb_pkg::DIV_BITS; k++) begin
      t = {rem, dq[rctb_pkg::DIV_W-1]};
      if (t >= {1'b0, rctb_pkg::DIVISOR}) begin
        rem = rctb_pkg::REM_W'(t - {1'b0, rctb_pkg::DIVISOR});
        dq  = {dq[rctb_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem = t[rctb_pkg::REM_W-1:0];
        dq  = {dq[rctb_pkg::DIV_W-2:0], 1'b0};
      end
    end
    dq_nxt  = dq;
    rem_nxt = rem;
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rctb_pkg::DIV_CNT_W'(rctb_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend in, quotient out through the same shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= rctb_pkg::DIV_W'(prod >> rctb_pkg::MS_SHIFT);
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Saturate a quotient wider than 32 bits
  assign ticks = (|dq_r[rctb_pkg::DIV_W-1:rctb_pkg::TICK_W]) ? '1 : dq_r[rctb_pkg::TICK_W-1:0];
  assign done  = done_r;

endmodule

[sv/rctb_cell.sv]
// One timer slot: counts, run counter, pending flag and the scan token stage.
module rctb_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rctb_pkg::rctb_cmd_t     cmd,
  input  logic                    sel,
  input  logic                    tok_in,
  output rctb_pkg::rctb_cell_st_t st
);

  logic [rctb_pkg::TICK_W-1:0] rem_r, rem_nxt;
  logic [rctb_pkg::TICK_W-1:0] reload_r, reload_nxt;
  logic [rctb_pkg::RUNS_W-1:0] runs_r, runs_nxt;
  logic                        pend_r, pend_nxt;
  logic                        tok_r, tok_nxt;

  // Apply the broadcast command to this slot
  always_comb begin
    rem_nxt    = rem_r;
    reload_nxt = reload_r;
    runs_nxt   = runs_r;
    pend_nxt   = pend_r;

    // Count down to one, then mark pending
    if (cmd.tick && (runs_r != rctb_pkg::RUNS_STOPPED)) begin
      if (rem_r > rctb_pkg::TICK_W'(1)) begin
        rem_nxt = rem_r - 1'b1;
      end else begin
        rem_nxt  = rctb_pkg::TICK_W'(1);
        pend_nxt = 1'b1;
      end
    end

    if (cmd.stop && sel) begin
      pend_nxt = 1'b0;
      runs_nxt = rctb_pkg::RUNS_STOPPED;
    end

    if (cmd.load && sel) begin
      rem_nxt    = cmd.ticks;
      reload_nxt = cmd.ticks;
      runs_nxt   = cmd.runs;
    end

    // Service this slot while it holds the scan token
    if (cmd.adv && tok_r && pend_r) begin
      pend_nxt = 1'b0;
      if (runs_r == rctb_pkg::RUNS_STOPPED) begin
        rem_nxt = '0;
      end else begin
        if (runs_r != rctb_pkg::RUNS_FOREVER) begin
          runs_nxt = runs_r - 1'b1;
        end
        rem_nxt = reload_r;
      end
    end

    // Pass the token along the row
    tok_nxt = cmd.shift ? tok_in : tok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      reload_r <= '0;
      runs_r   <= rctb_pkg::RUNS_STOPPED;
      pend_r   <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      reload_r <= reload_nxt;
      runs_r   <= runs_nxt;
      pend_r   <= pend_nxt;
      tok_r    <= tok_nxt;
    end
  end

  assign st.tok = tok_r;
  assign st.hit = tok_r && pend_r && (runs_r != rctb_pkg::RUNS_STOPPED);

endmodule

[sv/repeat_count_timer_bank_core.sv]
// Timer bank top level: sequencer, row of slot cells, converter and result register.
//
// A bank of NUM_TIMERS timer slots held in a row of cells. A stop or tick beat
// acts on the cells straight from idle. A start beat multiplies milliseconds by
// the tick rate, then runs eleven steps of the shared divider (four quotient bits
// per step), then loads the slot. A service scan passes a token down the row one
// slot per cycle, but holds it at a firing slot while an earlier fire cannot leave
// the full result register. Results leave through a single output register, so
// the bank takes the next beat while the last result of a scan still waits
// downstream. The tick rate must only be written while idle.
module repeat_count_timer_bank_core #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_we,
  input  logic [rctb_pkg::RATE_W-1:0]        cfg_wdata,
  // Command channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rctb_pkg::OP_W-1:0]          in_opcode,
  input  logic [rctb_pkg::ID_W-1:0]          in_target_timer,
  input  logic [rctb_pkg::MS_W-1:0]          in_duration_ms,
  input  logic [rctb_pkg::RUNS_W-1:0]        in_repeat_count,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_fired,
  output logic [rctb_pkg::TIMER_O_W-1:0]     out_fired_timer,
  output logic                               out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  rctb_pkg::rctb_state_t             state_r, state_nxt;
  rctb_pkg::rctb_op_t                op;
  rctb_pkg::rctb_cmd_t               cmd;
  rctb_pkg::rctb_cell_st_t           cell_st [NUM_TIMERS];

  logic [rctb_pkg::RATE_W-1:0]       tick_rate_r;
  logic [rctb_pkg::ID_W-1:0]         id_r, id_nxt, sel_id;
  logic [rctb_pkg::RUNS_W-1:0]       runs_r, runs_nxt;
  logic [IDX_W-1:0]                  scan_idx_r, scan_idx_nxt;
  logic                              held_v_r, held_v_nxt;
  logic [rctb_pkg::TIMER_O_W-1:0]    held_idx_r, held_idx_nxt;

  logic                              out_valid_r;
  logic                              out_fired_r;
  logic [rctb_pkg::TIMER_O_W-1:0]    out_timer_r;
  logic                              out_last_r;

  logic                              in_acc;
  logic                              out_free;
  logic                              cvt_start;
  logic                              cvt_done;
  logic [rctb_pkg::TICK_W-1:0]       cvt_ticks;
  logic                              scan_go;
  logic                              adv;
  logic                              hit_any;
  logic [NUM_TIMERS-1:0]             hit_vec;
  logic [NUM_TIMERS-1:0]             tok_vec;
  logic [NUM_TIMERS-1:0]             sel_vec;
  logic                              push_v;
  logic                              push_fired;
  logic [rctb_pkg::TIMER_O_W-1:0]    push_idx;
  logic                              push_last;

  // Hold the tick rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= rctb_pkg::TICK_RATE_RST;
    end else if (cfg_we) begin
      tick_rate_r <= cfg_wdata;
    end
  end

  assign in_stall = (state_r != rctb_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign op       = rctb_pkg::rctb_op_t'(in_opcode);
  assign out_free = !out_valid_r || !out_stall;
  assign hit_any  = |hit_vec;

  // Shared converter for start beats
  rctb_ms2tick u_ms2tick (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cvt_start),
    .ms    (in_duration_ms),
    .rate  (tick_rate_r),
    .done  (cvt_done),
    .ticks (cvt_ticks)
  );

  // Slot select: stop acts on the incoming id, load on the latched one
  assign sel_id = (state_r == rctb_pkg::ST_CONV) ? id_r : in_target_timer;

  // Row of slot cells, token enters at slot 0
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = scan_go;
    end else begin : g_link
      assign tok_in = tok_vec[i-1];
    end

    assign sel_vec[i] = (sel_id == rctb_pkg::ID_W'(i));

    rctb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .sel    (sel_vec[i]),
      .tok_in (tok_in),
      .st     (cell_st[i])
    );

    assign tok_vec[i] = cell_st[i].tok;
    assign hit_vec[i] = cell_st[i].hit;
  end

  // Next state, cell commands and result pushes
  always_comb begin
    state_nxt    = state_r;
    id_nxt       = id_r;
    runs_nxt     = runs_r;
    scan_idx_nxt = scan_idx_r;
    held_v_nxt   = held_v_r;
    held_idx_nxt = held_idx_r;
    cmd          = '0;
    cmd.ticks    = cvt_ticks;
    cmd.runs     = runs_r;
    cvt_start    = 1'b0;
    scan_go      = 1'b0;
    adv          = 1'b0;
    push_v       = 1'b0;
    push_fired   = 1'b0;
    push_idx     = '0;
    push_last    = 1'b0;

    case (state_r)
      rctb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            rctb_pkg::OP_START: begin
              // Drop starts aimed past the last slot
              if ({1'b0, in_target_timer} < (rctb_pkg::ID_W + 1)'(NUM_TIMERS)) begin
                cvt_start = 1'b1;
                id_nxt    = in_target_timer;
                runs_nxt  = in_repeat_count;
                state_nxt = rctb_pkg::ST_CONV;
              end
            end
            rctb_pkg::OP_STOP: begin
              cmd.stop = 1'b1;
            end
            rctb_pkg::OP_TICK: begin
              cmd.tick = 1'b1;
            end
            rctb_pkg::OP_SCAN: begin
              scan_go      = 1'b1;
              cmd.shift    = 1'b1;
              scan_idx_nxt = '0;
              held_v_nxt   = 1'b0;
              state_nxt    = rctb_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      rctb_pkg::ST_CONV: begin
        if (cvt_done) begin
          cmd.load  = 1'b1;
          state_nxt = rctb_pkg::ST_IDLE;
        end
      end

      rctb_pkg::ST_SCAN: begin
        // Hold the token while an earlier fire cannot leave
        adv = !(hit_any && held_v_r && !out_free);
        cmd.adv   = adv;
        cmd.shift = adv;
        if (adv) begin
          scan_idx_nxt = IDX_W'(scan_idx_r + 1'b1);
          if (hit_any) begin
            push_v       = held_v_r;
            push_fired   = 1'b1;
            push_idx     = held_idx_r;
            held_v_nxt   = 1'b1;
            held_idx_nxt = rctb_pkg::TIMER_O_W'(scan_idx_r);
          end
          if (tok_vec[NUM_TIMERS-1]) begin
            state_nxt = rctb_pkg::ST_FLUSH;
          end
        end
      end

      rctb_pkg::ST_FLUSH: begin
        // Close the scan with the held fire or an empty beat
        if (out_free) begin
          push_v     = 1'b1;
          push_fired = held_v_r;
          push_idx   = held_v_r ? held_idx_r : '0;
          push_last  = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = rctb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rctb_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rctb_pkg::ST_IDLE;
      held_v_r   <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      held_v_r   <= held_v_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    runs_r     <= runs_nxt;
    held_idx_r <= held_idx_nxt;
  end

  // Result register: load a beat or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      out_fired_r <= push_fired;
      out_timer_r <= push_idx;
      out_last_r  <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_fired_r;
  assign out_fired_timer = out_timer_r;
  assign out_last        = out_last_r;

  // A beat is only loaded into a free result register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_v |-> out_free)
    else $error("result beat overwrote an untaken beat");

  // Exactly one slot holds the token during a scan
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rctb_pkg::ST_SCAN) |-> $onehot(tok_vec))
    else $error("scan token lost or duplicated");

  // No token outside a scan
  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rctb_pkg::ST_SCAN) |-> (tok_vec == '0))
    else $error("stray scan token");

  // Converter completes only while a start waits on it
  a_cvt_done: assert property (@(posedge clk) disable iff (!rst_n)
    cvt_done |-> (state_r == rctb_pkg::ST_CONV))
    else $error("converter finished outside a start");

  // Every scan closes with a last beat
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rctb_pkg::ST_FLUSH && out_free) |=> (out_valid_r && out_last_r))
    else $error("scan ended without a last beat");

endmodule
